@@ rtl/acl_pkg.sv @@
package acl_pkg;

  localparam int unsigned ADDR_BITS = 7;
  localparam int unsigned DATA_BITS = 16;

  localparam int unsigned CACHE_LINES_DEF  = 5;
  localparam int unsigned LINE_WORDS_DEF   = 10;
  localparam int unsigned MEMORY_WORDS_DEF = 100;
  localparam int unsigned WORD_BITS_DEF    = 16;

  localparam int unsigned RANK_BITS = 3;
  localparam logic [RANK_BITS-1:0] RANK_MAX = 3'd7;

  typedef enum logic [2:0] {
    StIdle,
    StLookup,
    StWriteBack,
    StFill,
    StReadReq,
    StReadData,
    StResp
  } acl_state_e;

  typedef struct packed {
    logic capture;
    logic decide;
    logic wb_run;
    logic fill_run;
    logic rd_issue;
    logic rd_capture;
    logic out_load;
  } acl_cmd_t;

  typedef struct packed {
    logic oob;
    logic preload;
    logic found;
    logic has_empty;
    logic cnt_last;
    logic out_busy;
  } acl_stat_t;

endpackage

@@ rtl/acl_req_if.sv @@
interface acl_req_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic [acl_pkg::ADDR_BITS-1:0]         address;
  logic signed [acl_pkg::DATA_BITS-1:0]  write_value;

  modport source (output valid, mode, address, write_value, input ready);
  modport sink (input valid, mode, address, write_value, output ready);
endinterface

@@ rtl/acl_rsp_if.sv @@
interface acl_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [acl_pkg::DATA_BITS-1:0]  read_value;
  logic                                  status;
  logic                                  hit;
  logic                                  evicted;
  logic                                  bounds_flag;

  modport source (output valid, read_value, status, hit, evicted, bounds_flag, input ready);
  modport sink (input valid, read_value, status, hit, evicted, bounds_flag, output ready);
endinterface

@@ rtl/assoc_cache_lru_read_top.sv @@
// An out-of-bounds access or a preload is answered from the lookup; a read hit reads its word
// from the line RAM; a read miss fills an empty line first, or writes back a line and refills it.
// One word is in flight at a time; the next is accepted only once the result is loaded for output.
// Write-back and refill move one word a cycle through the one write and one read port
// of the line and memory RAMs.
// Reset invalidates all lines and clears ranks, tags, the bounds flag and the memory valid bits.
module assoc_cache_lru_read_top #(
  parameter int unsigned CACHE_LINES  = acl_pkg::CACHE_LINES_DEF,
  parameter int unsigned LINE_WORDS   = acl_pkg::LINE_WORDS_DEF,
  parameter int unsigned MEMORY_WORDS = acl_pkg::MEMORY_WORDS_DEF,
  parameter int unsigned WORD_BITS    = acl_pkg::WORD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  acl_req_if.sink   in_i,
  acl_rsp_if.source out_o
);
  import acl_pkg::*;

  acl_cmd_t  cmd;
  acl_stat_t stat;

  acl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  acl_dp #(
    .CACHE_LINES  (CACHE_LINES),
    .LINE_WORDS   (LINE_WORDS),
    .MEMORY_WORDS (MEMORY_WORDS),
    .WORD_BITS    (WORD_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (in_i.mode),
    .address_i     (in_i.address),
    .write_value_i (in_i.write_value),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .read_value_o  (out_o.read_value),
    .status_o      (out_o.status),
    .hit_o         (out_o.hit),
    .evicted_o     (out_o.evicted),
    .bounds_flag_o (out_o.bounds_flag)
  );

endmodule

@@ rtl/acl_ram.sv @@
module acl_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/acl_ctrl.sv @@
module acl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  acl_pkg::acl_stat_t stat_i,
  output acl_pkg::acl_cmd_t  cmd_o
);
  import acl_pkg::*;

  acl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StLookup;
      end
      StLookup: begin
        if (stat_i.oob || stat_i.preload) state_d = StResp;
        else if (stat_i.found) state_d = StReadReq;
        else if (stat_i.has_empty) state_d = StFill;
        else state_d = StWriteBack;
      end
      StWriteBack: begin
        if (stat_i.cnt_last) state_d = StFill;
      end
      StFill: begin
        if (stat_i.cnt_last) state_d = StReadReq;
      end
      StReadReq: begin
        state_d = StReadData;
      end
      StReadData: begin
        state_d = StResp;
      end
      StResp: begin
        if (!stat_i.out_busy) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StLookup: begin
        cmd_o.decide = 1'b1;
      end
      StWriteBack: begin
        cmd_o.wb_run = 1'b1;
      end
      StFill: begin
        cmd_o.fill_run = 1'b1;
      end
      StReadReq: begin
        cmd_o.rd_issue = 1'b1;
      end
      StReadData: begin
        cmd_o.rd_capture = 1'b1;
      end
      StResp: begin
        cmd_o.out_load = !stat_i.out_busy;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

@@ rtl/acl_dp.sv @@
module acl_dp #(
  parameter int unsigned CACHE_LINES  = acl_pkg::CACHE_LINES_DEF,
  parameter int unsigned LINE_WORDS   = acl_pkg::LINE_WORDS_DEF,
  parameter int unsigned MEMORY_WORDS = acl_pkg::MEMORY_WORDS_DEF,
  parameter int unsigned WORD_BITS    = acl_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  acl_pkg::acl_cmd_t                    cmd_i,
  output acl_pkg::acl_stat_t                   stat_o,
  input  logic                                 mode_i,
  input  logic [acl_pkg::ADDR_BITS-1:0]        address_i,
  input  logic signed [acl_pkg::DATA_BITS-1:0] write_value_i,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic signed [acl_pkg::DATA_BITS-1:0] read_value_o,
  output logic                                 status_o,
  output logic                                 hit_o,
  output logic                                 evicted_o,
  output logic                                 bounds_flag_o
);
  import acl_pkg::*;

  localparam int unsigned IDX_BITS = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int unsigned OFF_BITS = $clog2(LINE_WORDS);
  localparam int unsigned CNT_BITS = $clog2(LINE_WORDS + 1);
  localparam int unsigned LD_DEPTH = CACHE_LINES * LINE_WORDS;
  localparam int unsigned LD_AW    = $clog2(LD_DEPTH);
  localparam int unsigned MEM_AW   = $clog2(MEMORY_WORDS);
  localparam int unsigned SUM_BITS = ADDR_BITS + 1;
  localparam int unsigned ADDR_SPAN = 2 ** ADDR_BITS;

  // Request registers.
  logic                        req_mode_q;
  logic [ADDR_BITS-1:0]        req_addr_q;
  logic signed [DATA_BITS-1:0] req_wv_q;

  // Line state.
  logic [ADDR_BITS-1:0] tag_q [CACHE_LINES];
  logic [RANK_BITS-1:0] rank_q [CACHE_LINES];
  logic [RANK_BITS-1:0] rank_d [CACHE_LINES];
  logic [CACHE_LINES-1:0] line_vld_q;
  logic [MEMORY_WORDS-1:0] mem_vld_q;
  logic [IDX_BITS-1:0] sel_q;
  logic [CNT_BITS-1:0] cnt_q;
  logic sticky_q;
  logic fill_ok_q;

  // Result and output registers.
  logic [DATA_BITS-1:0] res_value_q;
  logic res_status_q, res_hit_q, res_evict_q;
  logic out_valid_q;
  logic [DATA_BITS-1:0] out_value_q;
  logic out_status_q, out_hit_q, out_evict_q, out_bounds_q;

  logic [ADDR_BITS-1:0] base_tab [ADDR_SPAN];
  logic [ADDR_BITS-1:0] base;
  logic [OFF_BITS-1:0]  off;
  logic oob, found, has_empty, cnt_last;
  logic [IDX_BITS-1:0] hit_idx, empty_idx, victim_idx, touch_idx;
  logic [RANK_BITS-1:0] best_rank;
  logic touch_en;
  logic [CNT_BITS-1:0] cnt_prev;
  logic [LD_AW-1:0] row_sel, row_hit;
  logic [SUM_BITS-1:0] wb_sum, fill_sum;
  logic [WORD_BITS-1:0] wv_word, fill_word;
  logic [CACHE_LINES-1:0] rank0_vec;

  logic ld_we;
  logic [LD_AW-1:0] ld_waddr, ld_raddr;
  logic [WORD_BITS-1:0] ld_wdata, ld_rdata;
  logic mem_we;
  logic [MEM_AW-1:0] mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

  for (genvar a = 0; a < ADDR_SPAN; a++) begin : g_base
    localparam int unsigned BASE = (a / LINE_WORDS) * LINE_WORDS;
    assign base_tab[a] = ADDR_BITS'(BASE);
  end

  assign base     = base_tab[req_addr_q];
  assign off      = OFF_BITS'(req_addr_q - base);
  assign oob      = {1'b0, req_addr_q} >= SUM_BITS'(MEMORY_WORDS);
  assign cnt_last = cnt_q == CNT_BITS'(LINE_WORDS);
  assign cnt_prev = cnt_q - 1'b1;
  assign wv_word  = WORD_BITS'(req_wv_q);
  assign row_sel  = LD_AW'(LD_AW'(sel_q) * LD_AW'(LINE_WORDS));
  assign row_hit  = LD_AW'(LD_AW'(hit_idx) * LD_AW'(LINE_WORDS));
  assign wb_sum   = SUM_BITS'(tag_q[sel_q]) + SUM_BITS'(cnt_prev[OFF_BITS-1:0]);
  assign fill_sum = SUM_BITS'(base) + SUM_BITS'(cnt_q);
  assign fill_word = fill_ok_q ? mem_rdata : '0;

  always_comb begin
    found      = 1'b0;
    hit_idx    = '0;
    has_empty  = 1'b0;
    empty_idx  = '0;
    victim_idx = '0;
    best_rank  = '0;
    for (int k = 0; k < CACHE_LINES; k++) begin
      if (!found && line_vld_q[k] && tag_q[k] == base) begin
        found   = 1'b1;
        hit_idx = IDX_BITS'(k);
      end
      if (!has_empty && !line_vld_q[k]) begin
        has_empty = 1'b1;
        empty_idx = IDX_BITS'(k);
      end
      if (rank_q[k] > best_rank) begin
        best_rank  = rank_q[k];
        victim_idx = IDX_BITS'(k);
      end
    end
  end

  assign touch_en  = (cmd_i.decide && !oob && !req_mode_q && found) ||
                     (cmd_i.fill_run && cnt_last);
  assign touch_idx = cmd_i.decide ? hit_idx : sel_q;

  always_comb begin
    rank_d = rank_q;
    if (touch_en) begin
      for (int k = 0; k < CACHE_LINES; k++) begin
        if (IDX_BITS'(k) == touch_idx) begin
          rank_d[k] = '0;
        end else if (line_vld_q[k] &&
                     (!line_vld_q[touch_idx] || rank_q[k] < rank_q[touch_idx]) &&
                     rank_q[k] != RANK_MAX) begin
          rank_d[k] = rank_q[k] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    ld_we    = 1'b0;
    ld_waddr = row_sel + LD_AW'(cnt_prev[OFF_BITS-1:0]);
    ld_wdata = fill_word;
    if (cmd_i.decide && !oob && req_mode_q && found) begin
      ld_we    = 1'b1;
      ld_waddr = row_hit + LD_AW'(off);
      ld_wdata = wv_word;
    end else if (cmd_i.fill_run && cnt_q != '0) begin
      ld_we = 1'b1;
    end
    ld_raddr = cmd_i.rd_issue ? row_sel + LD_AW'(off)
                              : row_sel + LD_AW'(cnt_q[OFF_BITS-1:0]);
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wb_sum[MEM_AW-1:0];
    mem_wdata = ld_rdata;
    if (cmd_i.decide && !oob && req_mode_q) begin
      mem_we    = 1'b1;
      mem_waddr = req_addr_q[MEM_AW-1:0];
      mem_wdata = wv_word;
    end else if (cmd_i.wb_run && cnt_q != '0 && wb_sum < SUM_BITS'(MEMORY_WORDS)) begin
      mem_we = 1'b1;
    end
    mem_raddr = fill_sum[MEM_AW-1:0];
  end

  acl_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (LD_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ld_we),
    .waddr_i (ld_waddr),
    .wdata_i (ld_wdata),
    .raddr_i (ld_raddr),
    .rdata_o (ld_rdata)
  );

  acl_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MEMORY_WORDS)
  ) u_mem_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_mode_q <= mode_i;
      req_addr_q <= address_i;
      req_wv_q   <= write_value_i;
    end
    if (cmd_i.decide) begin
      sel_q        <= found ? hit_idx : (has_empty ? empty_idx : victim_idx);
      res_status_q <= oob;
      res_hit_q    <= !oob && found;
      res_evict_q  <= !oob && !req_mode_q && !found && !has_empty;
      res_value_q  <= '0;
    end else if (cmd_i.rd_capture) begin
      res_value_q <= DATA_BITS'(ld_rdata);
    end
    // A word past the end of memory or never written reads as zero.
    fill_ok_q <= (fill_sum < SUM_BITS'(MEMORY_WORDS)) ? mem_vld_q[mem_raddr] : 1'b0;
    if (cmd_i.out_load) begin
      out_value_q  <= res_value_q;
      out_status_q <= res_status_q;
      out_hit_q    <= res_hit_q;
      out_evict_q  <= res_evict_q;
      out_bounds_q <= sticky_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < CACHE_LINES; k++) begin
        tag_q[k]  <= '0;
        rank_q[k] <= '0;
      end
      line_vld_q  <= '0;
      mem_vld_q   <= '0;
      cnt_q       <= '0;
      sticky_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rank_q <= rank_d;
      if (cmd_i.decide && oob) begin
        sticky_q <= 1'b1;
      end
      if (cmd_i.decide) begin
        cnt_q <= '0;
      end else if (cmd_i.wb_run || cmd_i.fill_run) begin
        cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
      end
      if (cmd_i.fill_run && cnt_last) begin
        tag_q[sel_q]      <= base;
        line_vld_q[sel_q] <= 1'b1;
      end
      if (mem_we) begin
        mem_vld_q[mem_waddr] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.oob       = oob;
  assign stat_o.preload   = req_mode_q;
  assign stat_o.found     = found;
  assign stat_o.has_empty = has_empty;
  assign stat_o.cnt_last  = cnt_last;
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_value_q;
  assign status_o      = out_status_q;
  assign hit_o         = out_hit_q;
  assign evicted_o     = out_evict_q;
  assign bounds_flag_o = out_bounds_q;

  always_comb begin
    for (int k = 0; k < CACHE_LINES; k++) begin
      rank0_vec[k] = line_vld_q[k] && rank_q[k] == '0;
    end
  end

  // Valid lines always hold distinct ranks, so only one of them can be the newest.
  a_single_newest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(rank0_vec) <= 1)
    else $error("more than one valid line has rank zero");

  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fill_run && cnt_last |=> line_vld_q[$past(sel_q)])
    else $error("filled line is not marked valid");

  a_wb_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wb_run |-> &line_vld_q)
    else $error("write-back started while an empty line exists");

  a_error_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q |-> out_bounds_q && !out_hit_q && !out_evict_q)
    else $error("error word carries hit, evict or a clear bounds flag");

endmodule

@@ tb/tb_assoc_cache_lru_read_top.sv @@
`timescale 1ns / 100ps

module tb_assoc_cache_lru_read_top;
  import acl_pkg::*;

  localparam int unsigned LINES     = CACHE_LINES_DEF;
  localparam int unsigned WORDS     = LINE_WORDS_DEF;
  localparam int unsigned MEM_DEPTH = MEMORY_WORDS_DEF;
  localparam int unsigned IDLE_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 2 * LINE_WORDS_DEF + 10;
  localparam int unsigned RANDOM_WORDS = 1300;

  localparam logic MODE_READ    = 1'b0;
  localparam logic MODE_PRELOAD = 1'b1;

  typedef struct packed {
    logic signed [DATA_BITS-1:0] read_value;
    logic                        status;
    logic                        hit;
    logic                        evicted;
    logic                        bounds_flag;
  } cache_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  acl_req_if req_if ();
  acl_rsp_if rsp_if ();

  assoc_cache_lru_read_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (rsp_if)
  );

  logic [DATA_BITS-1:0] mem_copy [MEM_DEPTH];
  logic [DATA_BITS-1:0] line_words [LINES][WORDS];
  int unsigned          line_base [LINES];
  bit                   line_live [LINES];
  logic [RANK_BITS-1:0] line_age [LINES];
  bit                   oob_sticky;

  cache_result_t pending_results [$];
  int unsigned   mismatch_count;
  int unsigned   idle_cycles;
  bit            no_idle;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void clear_cache_state();
    for (int i = 0; i < MEM_DEPTH; i++) mem_copy[i] = '0;
    for (int i = 0; i < LINES; i++) begin
      line_base[i] = 0;
      line_live[i] = 1'b0;
      line_age[i]  = '0;
    end
    oob_sticky = 1'b0;
  endfunction

  function automatic void age_others(int unsigned slot);
    for (int k = 0; k < LINES; k++) begin
      if (k != slot && line_live[k] &&
          (!line_live[slot] || line_age[k] < line_age[slot]) && line_age[k] < RANK_MAX) begin
        line_age[k] = line_age[k] + 1'b1;
      end
    end
    line_age[slot] = '0;
  endfunction

  function automatic cache_result_t predict_access(logic mode, logic [ADDR_BITS-1:0] addr,
                                                   logic [DATA_BITS-1:0] wv);
    cache_result_t r;
    int unsigned   base;
    int unsigned   off;
    int unsigned   slot;
    int unsigned   best;
    bit            found;
    r = '0;
    if (addr >= MEM_DEPTH) begin
      oob_sticky    = 1'b1;
      r.status      = 1'b1;
      r.bounds_flag = 1'b1;
      return r;
    end
    base  = (addr / WORDS) * WORDS;
    off   = addr % WORDS;
    found = 1'b0;
    slot  = 0;
    for (int i = 0; i < LINES; i++) begin
      if (!found && line_live[i] && line_base[i] == base) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (mode == MODE_PRELOAD) begin
      mem_copy[addr] = wv;
      if (found) line_words[slot][off] = wv;
    end else begin
      if (!found) begin
        slot = LINES;
        for (int i = 0; i < LINES; i++) begin
          if (slot == LINES && !line_live[i]) slot = i;
        end
        if (slot == LINES) begin
          best = 0;
          slot = 0;
          for (int i = 0; i < LINES; i++) begin
            if (line_age[i] > best) begin
              best = line_age[i];
              slot = i;
            end
          end
          for (int j = 0; j < WORDS; j++) begin
            if (line_base[slot] + j < MEM_DEPTH) mem_copy[line_base[slot] + j] = line_words[slot][j];
          end
          r.evicted = 1'b1;
        end
        for (int j = 0; j < WORDS; j++) begin
          line_words[slot][j] = (base + j < MEM_DEPTH) ? mem_copy[base + j] : '0;
        end
        age_others(slot);
        line_base[slot] = base;
        line_live[slot] = 1'b1;
      end else begin
        age_others(slot);
      end
      r.read_value = line_words[slot][off];
    end
    r.hit         = found;
    r.bounds_flag = oob_sticky;
    return r;
  endfunction

  task automatic send_word(input logic mode, input logic [ADDR_BITS-1:0] addr,
                           input logic [DATA_BITS-1:0] wv);
    int unsigned gap;
    gap = draw_wait();
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= mode;
    req_if.address     <= addr;
    req_if.write_value <= wv;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_access(mode, addr, wv));
  endtask

  task automatic test_cold_reads();
    send_word(MODE_READ, 7'd0, 16'h1234);
    send_word(MODE_READ, 7'd99, 16'h0000);
    send_word(MODE_PRELOAD, 7'd5, 16'h8000);
    send_word(MODE_PRELOAD, 7'd99, 16'h7FFF);
    send_word(MODE_READ, 7'd5, 16'hFFFF);
    send_word(MODE_READ, 7'd99, 16'h0000);
    send_word(MODE_PRELOAD, 7'd63, 16'hFFFF);
  endtask

  task automatic test_fill_and_evict();
    send_word(MODE_READ, 7'd10, 16'h0000);
    send_word(MODE_READ, 7'd20, 16'h0000);
    send_word(MODE_READ, 7'd39, 16'h0000);
    send_word(MODE_READ, 7'd11, 16'h0000);
    send_word(MODE_READ, 7'd40, 16'h0000);
    send_word(MODE_READ, 7'd5, 16'h0000);
    send_word(MODE_PRELOAD, 7'd77, 16'h5555);
    send_word(MODE_READ, 7'd77, 16'h0000);
    send_word(MODE_READ, 7'd64, 16'h0000);
    send_word(MODE_READ, 7'd99, 16'h0000);
  endtask

  task automatic test_out_of_bounds();
    send_word(MODE_READ, 7'd100, 16'h0000);
    send_word(MODE_READ, 7'd127, 16'hAAAA);
    send_word(MODE_PRELOAD, 7'd127, 16'h7FFF);
    send_word(MODE_PRELOAD, 7'd100, 16'h8000);
    send_word(MODE_READ, 7'd5, 16'h0000);
  endtask

  task automatic test_random_traffic();
    int unsigned hot_lines [8];
    int unsigned pick;
    logic [ADDR_BITS-1:0] addr;
    logic mode;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 200 == 0) begin
        for (int h = 0; h < 8; h++) hot_lines[h] = $urandom_range(0, MEM_DEPTH / WORDS - 1);
      end
      if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        addr = ADDR_BITS'(hot_lines[$urandom_range(0, 7)] * WORDS +
                          $urandom_range(0, WORDS - 1));
      end else if (pick < 92) begin
        addr = ADDR_BITS'($urandom_range(0, MEM_DEPTH - 1));
      end else begin
        addr = ADDR_BITS'($urandom_range(MEM_DEPTH, 127));
      end
      mode = ($urandom_range(0, 99) < 30) ? MODE_PRELOAD : MODE_READ;
      send_word(mode, addr, DATA_BITS'($urandom));
    end
    no_idle = 1'b0;
  endtask

  task automatic report_field(input string name, input int exp_val, input int act_val);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      int unsigned stall;
      stall = draw_wait();
      @(negedge clk_i);
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none, actual read_value %0d",
                 $time, rsp_if.read_value);
      end else begin
        cache_result_t exp_res;
        exp_res = pending_results.pop_front();
        if (rsp_if.read_value !== exp_res.read_value)
          report_field("read_value", exp_res.read_value, rsp_if.read_value);
        if (rsp_if.status !== exp_res.status)
          report_field("status", exp_res.status, rsp_if.status);
        if (rsp_if.hit !== exp_res.hit)
          report_field("hit", exp_res.hit, rsp_if.hit);
        if (rsp_if.evicted !== exp_res.evicted)
          report_field("evicted", exp_res.evicted, rsp_if.evicted);
        if (rsp_if.bounds_flag !== exp_res.bounds_flag)
          report_field("bounds_flag", exp_res.bounds_flag, rsp_if.bounds_flag);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_READ;
    req_if.address     = '0;
    req_if.write_value = '0;
    mismatch_count     = 0;
    idle_cycles        = 0;
    no_idle            = 1'b0;
    clear_cache_state();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_cold_reads();
    test_fill_and_evict();
    test_out_of_bounds();
    test_random_traffic();

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
